// File: rtl/core/flseq_pkg.sv
// shared types, constants and helper functions of the led frame sequencer
// no dependencies; every other file but flseq_fifo imports this package
package flseq_pkg;

    // payload widths
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned VALUE_W  = 14;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BRIGHT_W = 3;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ADDR_W   = 2;

    // default build settings
    localparam int unsigned NUM_DIGITS_DEF = 4;
    localparam int unsigned FIFO_DEPTH_DEF = 2;

    // command modes
    localparam logic [MODE_W-1:0] MODE_SHOW = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd2;

    // register map
    localparam logic [ADDR_W-1:0]   ADDR_BRIGHTNESS = 2'd0;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET    = 3'd1;

    // control bytes sent to the display driver
    localparam logic [BYTE_W-1:0] BYTE_WRITE_MODE = 8'h40;
    localparam logic [BYTE_W-1:0] BYTE_ADDR_START = 8'hC0;
    localparam logic [BYTE_W-1:0] BYTE_DISP_ON    = 8'h88;
    localparam logic [BYTE_W-1:0] BYTE_POWER_ON   = 8'h8F;
    localparam logic [BYTE_W-1:0] BYTE_POWER_OFF  = 8'h80;

    // input beat
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] value;
    } in_item_t;

    // result beat
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              start_before;
        logic              stop_after;
        logic              last;
    } out_item_t;

    // classified command between front and back
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    // ten to the power k, for elaboration-time constants
    function automatic int unsigned pow10_int(input int unsigned k);
        int unsigned acc;
        acc = 1;
        for (int unsigned i = 0; i < k; i++)
        begin
            acc = acc * 10;
        end
        return acc;
    endfunction

    // standard seven-segment pattern of one decimal digit
    function automatic logic [BYTE_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [BYTE_W-1:0] pat;
        case (digit)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

// File: rtl/core/four_digit_led_frame_sequencer.sv
// Frame sequencer for a two-wire four-digit seven-segment LED driver. Commands
// enter through a queue-style push/full port and framed bytes leave through an
// empty/pop port; each frame flags whether a start condition comes before and a
// stop after its byte, and the last frame of a command is marked. A show
// command yields NUM_DIGITS + 3 frames (seven at the default width) and a power
// command one frame; the back end emits one frame per cycle while the result
// queue has room, and takes the next command in the same cycle as the previous
// one's last frame. Values above the largest displayable number clamp to all
// nines. Brightness is a 3-bit register at byte address 0 of the APB port,
// reset to 1, and must only be written while no command is in flight.

// top level: config register, front end, command queue, back end, result queue
// depends on flseq_pkg, flseq_fifo, flseq_front and flseq_back
module four_digit_led_frame_sequencer #(
    parameter int unsigned NUM_DIGITS = flseq_pkg::NUM_DIGITS_DEF,
    parameter int unsigned FIFO_DEPTH = flseq_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  flseq_pkg::in_item_t           command,
    input  logic                          pop,
    output logic                          empty,
    output flseq_pkg::out_item_t          frame,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [flseq_pkg::ADDR_W-1:0]  paddr,
    input  logic [flseq_pkg::DATA_W-1:0]  pwdata,
    output logic [flseq_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    import flseq_pkg::*;

    logic [BRIGHT_W-1:0] bright_reg;
    logic                cfg_write;
    logic                cmd_push;
    logic                cmd_full;
    logic                cmd_empty;
    logic                cmd_pop;
    cmd_t                cmd_in;
    cmd_t                cmd_out;
    logic                res_push;
    logic                res_full;
    out_item_t           res_in;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_BRIGHTNESS);
    assign prdata    = (paddr == ADDR_BRIGHTNESS) ? DATA_W'(bright_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= BRIGHT_RESET;
        end
        else if (cfg_write)
        begin
            bright_reg <= pwdata[BRIGHT_W-1:0];
        end
    end

    // front end
    flseq_front #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_front (
        .command  (command),
        .push     (push),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd_data (cmd_in),
        .cmd_full (cmd_full)
    );

    // command queue between front and back
    flseq_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .full     (cmd_full),
        .data_in  (cmd_in),
        .pop      (cmd_pop),
        .empty    (cmd_empty),
        .data_out (cmd_out)
    );

    // back end
    flseq_back #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd_data   (cmd_out),
        .cmd_pop    (cmd_pop),
        .brightness (bright_reg),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_data   (res_in)
    );

    // result queue toward the serializer
    flseq_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .full     (res_full),
        .data_in  (res_in),
        .pop      (pop),
        .empty    (empty),
        .data_out (frame)
    );

endmodule

// File: rtl/core/flseq_fifo.sv
// small register-based first-in first-out queue with full and empty flags
// depends on nothing; depth must be a power of two of at least two
module flseq_fifo #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] data_in,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] data_out
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    // flags and handshake qualification
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = store_reg[rd_ptr_reg];

    // occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

// File: rtl/core/flseq_front.sv
// command front end: drops unused modes and clamps the display value
// depends on flseq_pkg
module flseq_front #(
    parameter int unsigned NUM_DIGITS = 4
) (
    input  flseq_pkg::in_item_t command,
    input  logic                push,
    output logic                full,
    output logic                cmd_push,
    output flseq_pkg::cmd_t     cmd_data,
    input  logic                cmd_full
);

    import flseq_pkg::*;

    localparam int unsigned VAL_MAX = pow10_int(NUM_DIGITS) - 1;

    logic known_mode;
    logic too_big;

    // back pressure comes straight from the command queue
    assign full = cmd_full;

    // mode three carries no work and is dropped on acceptance
    always_comb
    begin
        known_mode = command.mode inside {MODE_SHOW, MODE_ON, MODE_OFF};
        cmd_push   = push && !cmd_full && known_mode;
    end

    // clamp values past the largest number the digits can show
    always_comb
    begin
        too_big        = (32'(command.value) > 32'(VAL_MAX));
        cmd_data.mode  = command.mode;
        cmd_data.value = too_big ? VALUE_W'(VAL_MAX) : command.value;
    end

endmodule

// File: rtl/core/flseq_back.sv
// frame back end: expands one command into framed bytes, one per cycle unless
// res_full; depends on flseq_pkg; digits come out most significant first
module flseq_back #(
    parameter int unsigned NUM_DIGITS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_empty,
    input  flseq_pkg::cmd_t                  cmd_data,
    output logic                             cmd_pop,
    input  logic [flseq_pkg::BRIGHT_W-1:0]   brightness,
    input  logic                             res_full,
    output logic                             res_push,
    output flseq_pkg::out_item_t             res_data
);

    import flseq_pkg::*;

    localparam int unsigned WEIGHT     = pow10_int(NUM_DIGITS - 1);
    localparam int unsigned REM_W      = $clog2(pow10_int(NUM_DIGITS));
    localparam int unsigned EXT_W      = REM_W + 4;
    localparam int unsigned FRAME_W    = $clog2(NUM_DIGITS + 3);
    localparam int unsigned LAST_FRAME = NUM_DIGITS + 2;
    localparam int unsigned LAST_DIGIT = NUM_DIGITS + 1;

    logic               busy_reg;
    logic               busy_next;
    logic [MODE_W-1:0]  mode_reg;
    logic [MODE_W-1:0]  mode_next;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   rem_next;
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] frame_next;

    logic               emit;
    logic               is_last;
    logic               digit_frame;
    logic [3:0]         digit;
    logic [EXT_W-1:0]   rem_ext;
    logic [EXT_W-1:0]   sub_val;
    logic [EXT_W-1:0]   rem_low;
    logic [EXT_W-1:0]   rem_shift;

    // leading digit of the remainder by parallel compares against j * weight
    always_comb
    begin
        rem_ext = EXT_W'(rem_reg);
        digit   = 4'd0;
        sub_val = '0;
        for (int j = 1; j <= 9; j++)
        begin
            if (rem_ext >= EXT_W'(j * WEIGHT))
            begin
                digit   = 4'(j);
                sub_val = EXT_W'(j * WEIGHT);
            end
        end
        rem_low   = rem_ext - sub_val;
        rem_shift = (rem_low << 3) + (rem_low << 1);
    end

    // frame position decode
    always_comb
    begin
        digit_frame = (frame_reg >= FRAME_W'(2)) && (frame_reg <= FRAME_W'(LAST_DIGIT));
        is_last     = (mode_reg != MODE_SHOW) || (frame_reg == FRAME_W'(LAST_FRAME));
        emit        = busy_reg && !res_full;
        res_push    = emit;
    end

    // frame contents
    always_comb
    begin
        res_data.data_byte    = BYTE_DISP_ON | BYTE_W'(brightness);
        res_data.start_before = 1'b1;
        res_data.stop_after   = 1'b1;
        res_data.last         = 1'b1;
        case (mode_reg)
            MODE_ON:
            begin
                res_data.data_byte = BYTE_POWER_ON;
            end
            MODE_OFF:
            begin
                res_data.data_byte = BYTE_POWER_OFF;
            end
            default:
            begin
                if (frame_reg == FRAME_W'(0))
                begin
                    res_data.data_byte = BYTE_WRITE_MODE;
                    res_data.last      = 1'b0;
                end
                else if (frame_reg == FRAME_W'(1))
                begin
                    res_data.data_byte  = BYTE_ADDR_START;
                    res_data.stop_after = 1'b0;
                    res_data.last       = 1'b0;
                end
                else if (digit_frame)
                begin
                    res_data.data_byte    = seg_pattern(digit);
                    res_data.start_before = 1'b0;
                    res_data.stop_after   = (frame_reg == FRAME_W'(LAST_DIGIT));
                    res_data.last         = 1'b0;
                end
            end
        endcase
    end

    // sequencing: take the next command in the same cycle the last frame leaves
    always_comb
    begin
        cmd_pop    = !cmd_empty && (!busy_reg || (emit && is_last));
        busy_next  = busy_reg;
        mode_next  = mode_reg;
        rem_next   = rem_reg;
        frame_next = frame_reg;
        if (cmd_pop)
        begin
            busy_next  = 1'b1;
            mode_next  = cmd_data.mode;
            rem_next   = REM_W'(cmd_data.value);
            frame_next = '0;
        end
        else if (emit && is_last)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            frame_next = frame_reg + FRAME_W'(1);
            if (digit_frame)
            begin
                rem_next = REM_W'(rem_shift);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            frame_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            frame_reg <= frame_next;
        end
    end

    // command payload
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        rem_reg  <= rem_next;
    end

endmodule

// File: rtl/core/flseq_checker.sv
// port-level checks of the led frame sequencer, bound to the top level
// depends on flseq_pkg and four_digit_led_frame_sequencer
module flseq_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop,
    input  logic                          empty,
    input  flseq_pkg::out_item_t          frame,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [flseq_pkg::ADDR_W-1:0]  paddr,
    input  logic [flseq_pkg::DATA_W-1:0]  pwdata,
    input  logic [flseq_pkg::DATA_W-1:0]  prdata,
    input  logic                          pready
);

    import flseq_pkg::*;

    // nothing waits on the result side after reset
    assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty after reset");

    // a command's frames follow on the result side without a gap once the first one is popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !frame.last) |=> !empty)
        else $error("gap inside a command's frame sequence");

    // a command always ends on a fully framed byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame.last) |-> (frame.start_before && frame.stop_after))
        else $error("final frame lacks start or stop condition");

    // brightness reads back what was written
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr == ADDR_BRIGHTNESS))
        ##1 (paddr == ADDR_BRIGHTNESS)
        |-> (prdata == DATA_W'($past(pwdata[BRIGHT_W-1:0]))))
        else $error("brightness readback mismatch");

endmodule

bind four_digit_led_frame_sequencer flseq_checker u_flseq_checker (.*);

// File: test/four_digit_led_frame_sequencer_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the four-digit led frame sequencer: a queued command driver,
// a frame monitor, brightness writes over apb and a frame predictor with its own state
// depends on flseq_pkg and four_digit_led_frame_sequencer
module four_digit_led_frame_sequencer_tb;

    import flseq_pkg::*;

    localparam int unsigned DIGITS     = 4;
    localparam int unsigned MAX_SHOWN  = 10 ** DIGITS - 1;
    localparam int unsigned SETTLE     = 24;
    localparam int unsigned CYCLE_CAP  = 200000;
    localparam int unsigned PHASE_LEN  = 60;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // seven-segment shapes of the decimal digits
    localparam logic [BYTE_W-1:0] SHAPES [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    logic                  clk;
    logic                  rst_n   = 1'b0;
    logic                  push    = 1'b0;
    logic                  full;
    in_item_t              command = '0;
    logic                  pop     = 1'b0;
    logic                  empty;
    out_item_t             frame;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_W-1:0]     paddr   = '0;
    logic [DATA_W-1:0]     pwdata  = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    in_item_t              command_queue [$];
    out_item_t             frame_expect [$];
    logic [BRIGHT_W-1:0]   bright_level = BRIGHT_RESET;
    int unsigned           mismatches   = 0;
    bit                    steady       = 1'b0;

    four_digit_led_frame_sequencer #(
        .NUM_DIGITS(DIGITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .command (command),
        .pop     (pop),
        .empty   (empty),
        .frame   (frame),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void add_frame(input logic [BYTE_W-1:0] b, input logic st,
                                      input logic sp, input logic lst);
        out_item_t f;
        f.data_byte    = b;
        f.start_before = st;
        f.stop_after   = sp;
        f.last         = lst;
        frame_expect.push_back(f);
    endfunction

    // frames that one accepted command must produce
    function automatic void predict_frames(input in_item_t c);
        int unsigned shown;
        int unsigned digit [DIGITS];
        case (c.mode)
            MODE_ON:  add_frame(BYTE_POWER_ON, 1'b1, 1'b1, 1'b1);
            MODE_OFF: add_frame(BYTE_POWER_OFF, 1'b1, 1'b1, 1'b1);
            MODE_SHOW:
            begin
                shown = c.value;
                if (shown > MAX_SHOWN)
                    shown = MAX_SHOWN;
                for (int i = 0; i < DIGITS; i++)
                begin
                    digit[i] = shown % 10;
                    shown    = shown / 10;
                end
                add_frame(BYTE_WRITE_MODE, 1'b1, 1'b1, 1'b0);
                add_frame(BYTE_ADDR_START, 1'b1, 1'b0, 1'b0);
                for (int i = DIGITS - 1; i >= 0; i--)
                    add_frame(SHAPES[digit[i]], 1'b0, i == 0, 1'b0);
                add_frame(BYTE_DISP_ON | BYTE_W'(bright_level), 1'b1, 1'b1, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function automatic in_item_t make_command(input logic [MODE_W-1:0] m,
                                              input int unsigned v);
        in_item_t c;
        c.mode  = m;
        c.value = VALUE_W'(v);
        return c;
    endfunction

    // random command, mostly show with in-range values
    function automatic in_item_t random_command();
        int unsigned pick;
        int unsigned v;
        pick = $urandom_range(99);
        v    = ($urandom_range(3) == 0) ? $urandom_range(16383) : $urandom_range(MAX_SHOWN);
        if (pick < 70)
            return make_command(MODE_SHOW, v);
        else if (pick < 80)
            return make_command(MODE_ON, $urandom_range(16383));
        else if (pick < 90)
            return make_command(MODE_OFF, $urandom_range(16383));
        return make_command(MODE_UNUSED, $urandom_range(16383));
    endfunction

    // command driver: holds a beat until accepted, then maybe idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push    <= 1'b0;
            command <= '0;
        end
        else
        begin
            if (push && !full)
                predict_frames(command);
            if (!push || !full)
            begin
                if (command_queue.size() != 0 && (steady || $urandom_range(99) >= 35))
                begin
                    push    <= 1'b1;
                    command <= command_queue.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // frame monitor: random stalls, each accepted beat checked against the oldest frame
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (frame_expect.size() == 0)
                begin
                    $error("unexpected frame: data_byte %h", frame.data_byte);
                    mismatches++;
                end
                else
                begin
                    out_item_t want;
                    want = frame_expect.pop_front();
                    if (frame.data_byte !== want.data_byte)
                    begin
                        $error("data_byte: expected %h, got %h", want.data_byte,
                               frame.data_byte);
                        mismatches++;
                    end
                    if (frame.start_before !== want.start_before)
                    begin
                        $error("start_before: expected %b, got %b", want.start_before,
                               frame.start_before);
                        mismatches++;
                    end
                    if (frame.stop_after !== want.stop_after)
                    begin
                        $error("stop_after: expected %b, got %b", want.stop_after,
                               frame.stop_after);
                        mismatches++;
                    end
                    if (frame.last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, frame.last);
                        mismatches++;
                    end
                end
            end
            pop <= steady || ($urandom_range(99) >= 35);
        end
    end

    // watchdog
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_CAP)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // wait until the sender is done and every frame has come, then let the block settle
    task automatic drain();
        while (command_queue.size() != 0 || push || frame_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // apb write of the brightness register, upper data bits random, then a read back
    task automatic set_brightness(input logic [BRIGHT_W-1:0] level);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BRIGHTNESS;
        pwdata  <= ($urandom & ~DATA_W'(7)) | DATA_W'(level);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        bright_level = level;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== DATA_W'(level))
        begin
            $error("brightness: expected %h, got %h", DATA_W'(level), prdata);
            mismatches++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stimulus sequence
    initial
    begin
        logic [BRIGHT_W-1:0] levels [5];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed commands at the reset brightness
        command_queue.push_back(make_command(MODE_SHOW, 0));
        command_queue.push_back(make_command(MODE_SHOW, MAX_SHOWN));
        command_queue.push_back(make_command(MODE_SHOW, MAX_SHOWN + 1));
        command_queue.push_back(make_command(MODE_SHOW, 16383));
        command_queue.push_back(make_command(MODE_SHOW, 1234));
        command_queue.push_back(make_command(MODE_SHOW, 5678));
        command_queue.push_back(make_command(MODE_SHOW, 9080));
        command_queue.push_back(make_command(MODE_SHOW, 1));
        command_queue.push_back(make_command(MODE_SHOW, 10));
        command_queue.push_back(make_command(MODE_SHOW, 100));
        command_queue.push_back(make_command(MODE_SHOW, 1000));
        command_queue.push_back(make_command(MODE_SHOW, 8192));
        command_queue.push_back(make_command(MODE_ON, 0));
        command_queue.push_back(make_command(MODE_ON, 16383));
        command_queue.push_back(make_command(MODE_OFF, 0));
        command_queue.push_back(make_command(MODE_OFF, 16383));
        command_queue.push_back(make_command(MODE_UNUSED, 0));
        command_queue.push_back(make_command(MODE_UNUSED, 16383));
        command_queue.push_back(make_command(MODE_SHOW, 4321));
        drain();

        // random phases, each at its own brightness; the middle one never idles
        levels[0] = 3'd0;
        levels[1] = 3'd7;
        levels[2] = BRIGHT_W'($urandom_range(7));
        levels[3] = BRIGHT_W'($urandom_range(7));
        levels[4] = 3'd5;
        for (int p = 0; p < 5; p++)
        begin
            set_brightness(levels[p]);
            steady = (p == 2);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                in_item_t c;
                c = random_command();
                command_queue.push_back(c);
            end
            drain();
            steady = 1'b0;
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
